// ===== hw/rtl/hbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed block classifier package
// Shared types, hash constants and 64-bit multiply helpers built from
// 32-bit partial products.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_B  = 64'h94D049BB133111EB;

    localparam logic [12:0] PCT_SCALE = 13'd100;

    localparam logic [63:0] TAG_HOLE   = 64'd1;
    localparam logic [63:0] TAG_DUP    = 64'd2;
    localparam logic [63:0] TAG_PICK   = 64'd3;
    localparam logic [63:0] TAG_UNIQUE = 64'd4;
    localparam logic [63:0] TAG_CORPUS = 64'd5;

    localparam int LAT_MIX   = 4;
    localparam int DIV_STEPS = 64;

    typedef enum logic [1:0] {
        KIND_HOLE   = 2'd0,
        KIND_DUP    = 2'd1,
        KIND_UNIQUE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SPARSE = 2'd0,
        CFG_DEDUP  = 2'd1,
        CFG_CORPUS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] file_seed;
        logic [63:0] block_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  block_kind;
        logic [63:0] source_key;
        logic [31:0] corpus_index;
    } t_out_item;

    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] mid_a;
        logic [31:0] mid_b;
    } t_pp;

    function automatic t_pp pp64(input logic [63:0] a, input logic [63:0] b);
        t_pp         p;
        logic [63:0] ta;
        logic [63:0] tb;
        p.lo    = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        ta      = {32'd0, a[31:0]} * {32'd0, b[63:32]};
        tb      = {32'd0, a[63:32]} * {32'd0, b[31:0]};
        p.mid_a = ta[31:0];
        p.mid_b = tb[31:0];
        return p;
    endfunction

    function automatic logic [63:0] pp_sum(input t_pp p);
        logic [31:0] mid;
        mid = p.mid_a + p.mid_b;
        return p.lo + {mid, 32'd0};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hbc_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed block classifier mix stage
// Four-stage pipelined splitmix64 finalizer; advances when enabled.
// ----------------------------------------------------------------------------
module hbc_mix (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_data,
    output logic      [63:0] o_data
);
    import hbc_pkg::*;

    t_pp         r_p1;
    logic [63:0] r_y;
    t_pp         r_p2;
    logic [63:0] r_w;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= pp64(i_data ^ (i_data >> 30), MIX_A);
            r_y  <= pp_sum(r_p1);
            r_p2 <= pp64(r_y ^ (r_y >> 27), MIX_B);
            r_w  <= pp_sum(r_p2);
        end
    end

    assign o_data = r_w ^ (r_w >> 31);

endmodule
`default_nettype wire

// ===== hw/rtl/hashed_block_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed block classifier
// Classifies each block as hole, corpus duplicate or unique and gives its key.
// The remainder pipeline has 64 steps. Throughput is one item per cycle
// while the output register is not stalled.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module hashed_block_classifier (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire hbc_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output hbc_pkg::t_out_item     o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);
    import hbc_pkg::*;

    localparam int NPCT     = 2;
    localparam int FLAG_DLY = DIV_STEPS - 4;
    localparam int TAIL     = LAT_MIX + 1 + LAT_MIX;
    localparam int VLD_LEN  = 2 + LAT_MIX + 1 + LAT_MIX + DIV_STEPS + 1 + TAIL;

    logic        en;
    logic [6:0]  r_sparse;
    logic [6:0]  r_dedup;
    logic [31:0] r_corpus;

    logic [VLD_LEN-1:0] r_vld;
    logic               r_out_valid;
    t_out_item          r_out;

    t_pp         r_pp0;
    logic [63:0] r_blk0;
    logic [63:0] r_lin;
    logic [63:0] m;
    logic [63:0] r_t [4];
    logic [63:0] h [4];

    logic [23:0] r_fa [NPCT];
    logic [13:0] r_fb [NPCT];
    logic [12:0] r_fc [NPCT];
    logic [6:0]  r_pr [NPCT];
    logic [23:0] n_fa [NPCT];
    logic [13:0] n_fb [NPCT];
    logic [12:0] n_fc [NPCT];
    logic [6:0]  n_pr [NPCT];
    logic        r_hole_d [FLAG_DLY];
    logic        r_dup_d  [FLAG_DLY];

    logic [32:0] r_rem [DIV_STEPS];
    logic [63:0] r_num [DIV_STEPS];
    logic [63:0] r_hk  [DIV_STEPS];
    logic [32:0] n_rem [DIV_STEPS];
    logic [63:0] n_num [DIV_STEPS];

    logic        hole;
    logic        dup;
    t_kind       r_kind;
    logic [31:0] r_idx;
    logic [63:0] r_ukey;
    logic [63:0] c0;
    logic [63:0] r_c;
    logic [63:0] c1;
    t_kind       r_kind_d [TAIL];
    logic [31:0] r_idx_d  [TAIL];
    logic [63:0] r_ukey_d [TAIL];

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sparse <= '0;
            r_dedup  <= '0;
            r_corpus <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPARSE: r_sparse <= i_cfg_data[6:0];
                CFG_DEDUP:  r_dedup  <= i_cfg_data[6:0];
                CFG_CORPUS: r_corpus <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[VLD_LEN-2:0], i_in_valid};
            r_out_valid <= r_vld[VLD_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp0  <= pp64(i_in_data.file_seed, GOLDEN);
            r_blk0 <= i_in_data.block_index;
            r_lin  <= pp_sum(r_pp0) + r_blk0;
            r_t[0] <= m + TAG_HOLE;
            r_t[1] <= m + TAG_DUP;
            r_t[2] <= m + TAG_PICK;
            r_t[3] <= m + TAG_UNIQUE;
        end
    end

    hbc_mix u_mix_in (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (r_lin),
        .o_data (m)
    );

    for (genvar k = 0; k < 4; k++) begin : g_tag
        hbc_mix u_mix_tag (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_data (r_t[k]),
            .o_data (h[k])
        );
    end

    // The hash is folded by residues of powers of two mod 100, then a
    // reciprocal multiply gives the exact remainder of the small sum.
    always_comb begin
        logic [18:0] t1;
        logic [25:0] prod;
        logic [12:0] qm;
        logic [12:0] rm;
        for (int l = 0; l < NPCT; l++) begin
            n_fa[l] = {8'd0, h[l][15:0]} + {8'd0, h[l][31:16]} * 24'd36
                    + {8'd0, h[l][47:32]} * 24'd96 + {8'd0, h[l][63:48]} * 24'd56;
            t1      = {7'd0, r_fa[l][11:0]} + {7'd0, r_fa[l][23:12]} * 19'd96;
            n_fb[l] = {2'd0, t1[11:0]} + {7'd0, t1[18:12]} * 14'd96;
            n_fc[l] = {1'b0, r_fb[l][11:0]} + {11'd0, r_fb[l][13:12]} * 13'd96;
            prod    = {13'd0, r_fc[l]} * 26'd5243;
            qm      = {6'd0, prod[25:19]} * PCT_SCALE;
            rm      = r_fc[l] - qm;
            n_pr[l] = rm[6:0];
        end
    end

    always_comb begin
        logic [32:0] rin;
        logic [63:0] nin;
        logic [32:0] t;
        for (int j = 0; j < DIV_STEPS; j++) begin
            rin = (j == 0) ? 33'd0 : r_rem[(j == 0) ? 0 : j - 1];
            nin = (j == 0) ? h[2] : r_num[(j == 0) ? 0 : j - 1];
            t   = {rin[31:0], nin[63]};
            n_rem[j] = (t >= {1'b0, r_corpus}) ? t - {1'b0, r_corpus} : t;
            n_num[j] = {nin[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NPCT; l++) begin
                r_fa[l] <= n_fa[l];
                r_fb[l] <= n_fb[l];
                r_fc[l] <= n_fc[l];
                r_pr[l] <= n_pr[l];
            end
            r_hole_d[0] <= (r_sparse != 7'd0) && (r_pr[0] < r_sparse);
            r_dup_d[0]  <= (r_dedup != 7'd0) && (r_corpus != 32'd0)
                        && (r_pr[1] < r_dedup);
            for (int j = 1; j < FLAG_DLY; j++) begin
                r_hole_d[j] <= r_hole_d[j-1];
                r_dup_d[j]  <= r_dup_d[j-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_rem[j] <= n_rem[j];
                r_num[j] <= n_num[j];
            end
            r_hk[0] <= h[3];
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_hk[j] <= r_hk[j-1];
            end
        end
    end

    assign hole = r_hole_d[FLAG_DLY-1];
    assign dup  = r_dup_d[FLAG_DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ukey <= r_hk[DIV_STEPS-1];
            if (hole) begin
                r_kind <= KIND_HOLE;
                r_idx  <= '0;
            end else if (dup) begin
                r_kind <= KIND_DUP;
                r_idx  <= r_rem[DIV_STEPS-1][31:0];
            end else begin
                r_kind <= KIND_UNIQUE;
                r_idx  <= '0;
            end
            r_c <= c0 + TAG_CORPUS;
            r_kind_d[0] <= r_kind;
            r_idx_d[0]  <= r_idx;
            r_ukey_d[0] <= r_ukey;
            for (int j = 1; j < TAIL; j++) begin
                r_kind_d[j] <= r_kind_d[j-1];
                r_idx_d[j]  <= r_idx_d[j-1];
                r_ukey_d[j] <= r_ukey_d[j-1];
            end
            r_out.block_kind   <= r_kind_d[TAIL-1];
            r_out.corpus_index <= r_idx_d[TAIL-1];
            case (r_kind_d[TAIL-1])
                KIND_HOLE: r_out.source_key <= '0;
                KIND_DUP:  r_out.source_key <= c1;
                default:   r_out.source_key <= r_ukey_d[TAIL-1];
            endcase
        end
    end

    hbc_mix u_mix_c0 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({32'd0, r_idx}),
        .o_data (c0)
    );

    hbc_mix u_mix_c1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (r_c),
        .o_data (c1)
    );

endmodule
`default_nettype wire
